>>> rtl/core/tdsr_pkg.sv
// ----------------------------------------------------------------------------
// tdsr_pkg
// Shared types and constants of the text display scroll refresher.
// ----------------------------------------------------------------------------
package tdsr_pkg;

  localparam int ROW_W      = 3;   // row and screen line numbers
  localparam int ROW_SLOTS  = 8;   // rows addressable by a row number
  localparam int COL_W      = 5;   // column counts, up to 31
  localparam int ITER_W     = 4;   // row scan counter, up to 8
  localparam int CMD_W      = 3;
  localparam int CHAR_W     = 8;
  localparam int TIME_W     = 32;
  localparam int KIND_W     = 2;
  localparam int LINES_W    = 4;
  localparam int MODE_W     = 2;
  localparam int IVL_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_SELECT  = 3'd0,
    CMD_APPEND  = 3'd1,
    CMD_CLEAR   = 3'd2,
    CMD_STEP    = 3'd3,
    CMD_RESTART = 3'd4
  } cmd_e;

  typedef enum logic [KIND_W-1:0] {
    OP_SETPOS = 2'd0,
    OP_WRITE  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE     = 2'd0,
    CFG_LINES    = 2'd1,
    CFG_INTERVAL = 2'd2
  } cfg_idx_e;

  localparam logic [MODE_W-1:0]  MODE_CONT  = 2'd0;
  localparam logic [MODE_W-1:0]  MODE_PAGE  = 2'd1;
  localparam logic [CHAR_W-1:0]  CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0]  CHAR_NUL   = 8'h00;
  localparam logic [LINES_W-1:0] MAX_LINES  = 4'd8;

  localparam logic [MODE_W-1:0]  RST_MODE     = 2'd0;
  localparam logic [LINES_W-1:0] RST_LINES    = 4'd2;
  localparam logic [IVL_W-1:0]   RST_INTERVAL = 16'd3000;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [LINES_W-1:0] lines;
    logic [IVL_W-1:0]   interval;
  } cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ROW_W-1:0]  row_index;
    logic [CHAR_W-1:0] char_code;
    logic [TIME_W-1:0] now_ms;
  } item_t;

  typedef struct packed {
    op_kind_e          kind;
    logic [ROW_W-1:0]  line;
    logic [CHAR_W-1:0] ch;
  } result_t;

  typedef struct packed {
    logic              sel;
    logic              app;
    logic              clr;
    logic [ROW_W-1:0]  row;
    logic [CHAR_W-1:0] ch;
  } txt_cmd_t;

  typedef struct packed {
    logic [ROW_W-1:0] next;
    logic             next_nb;
    logic             next_first;
    logic             cur_nb;
  } row_step_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SEEK,
    ST_COPY,
    ST_NEXT_ROW,
    ST_FINISH,
    ST_ROTATE,
    ST_EMIT
  } seq_state_e;

  // bits of a column index into a row of the given length
  function automatic int col_idx_w(input int cols);
    return (cols > 1) ? $clog2(cols) : 1;
  endfunction

endpackage

>>> rtl/core/tdsr_if.sv
// ----------------------------------------------------------------------------
// tdsr_if
// Valid/ready channels of the refresher: command items, screen operations
// and register writes.
// ----------------------------------------------------------------------------
interface tdsr_in_if import tdsr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [ROW_W-1:0]  row_index;
  logic [CHAR_W-1:0] char_code;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, output cmd, output row_index, output char_code,
                  output now_ms, input ready);
  modport sink   (input valid, input cmd, input row_index, input char_code,
                  input now_ms, output ready);
endinterface

interface tdsr_out_if import tdsr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] op_kind;
  logic [ROW_W-1:0]  op_line;
  logic [CHAR_W-1:0] op_char;

  modport source (output valid, output op_kind, output op_line, output op_char,
                  input ready);
  modport sink   (input valid, input op_kind, input op_line, input op_char,
                  output ready);
endinterface

interface tdsr_cfg_if import tdsr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/text_display_scroll_refresher_core.sv
// ----------------------------------------------------------------------------
// text_display_scroll_refresher_core
// Text row store and character screen refresher, at most one operation per step.
// ----------------------------------------------------------------------------
// One item is taken at a time; in_i.ready is low until its work is done.
// Select, append and unused commands, and a refresh step stopped by the time
// gate, give no result; clear gives one. The last character write of a line
// goes on to find the next filled row, one row per cycle through the single
// row stepper, then at end of screen a finish step and, for by-row scrolling,
// a search for the new top row. A set-position step searches for a filled
// row, then copies its visible characters from the text memory through its
// single read port. Results wait in an output register; a finished operation
// that finds it full holds the block until the screen side takes it. Register
// writes are taken at any time and have no result. The text memory has no
// reset and no clearing pass; row lengths live in flip-flops.
module text_display_scroll_refresher_core import tdsr_pkg::*; #(
  parameter int TEXT_ROWS = 8,
  parameter int TEXT_COLS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tdsr_cfg_if.sink   cfg_i,
  tdsr_in_if.sink    in_i,
  tdsr_out_if.source out_o
);

  localparam int CW = col_idx_w(TEXT_COLS);

  cfg_t                 cfg_q, cfg_d;
  item_t                item;
  txt_cmd_t             txt_cmd;
  logic [ROW_W-1:0]     scan_row;
  logic [COL_W-1:0]     scan_len;
  logic [ROW_SLOTS-1:0] nonblank;
  logic [ROW_W+CW-1:0]  rd_addr;
  logic [CHAR_W-1:0]    rd_data;
  logic                 res_valid;
  logic                 res_ready;
  result_t              res;
  logic                 out_valid_q, out_valid_d;
  result_t              out_q;

  // register writes
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_MODE:     cfg_d.mode     = cfg_i.data[MODE_W-1:0];
        CFG_LINES:    cfg_d.lines    = cfg_i.data[LINES_W-1:0];
        CFG_INTERVAL: cfg_d.interval = cfg_i.data[IVL_W-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{mode: RST_MODE, lines: RST_LINES, interval: RST_INTERVAL};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign item = '{cmd: in_i.cmd, row_index: in_i.row_index,
                  char_code: in_i.char_code, now_ms: in_i.now_ms};

  tdsr_text_store #(
    .TEXT_ROWS (TEXT_ROWS),
    .TEXT_COLS (TEXT_COLS)
  ) u_text_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .txt_cmd_i  (txt_cmd),
    .scan_row_i (scan_row),
    .scan_len_o (scan_len),
    .nonblank_o (nonblank),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (rd_data)
  );

  tdsr_refresh_seq #(
    .TEXT_ROWS (TEXT_ROWS),
    .TEXT_COLS (TEXT_COLS)
  ) u_refresh_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (in_i.valid),
    .item_ready_o (in_i.ready),
    .item_i       (item),
    .cfg_i        (cfg_q),
    .txt_cmd_o    (txt_cmd),
    .scan_row_o   (scan_row),
    .scan_len_i   (scan_len),
    .nonblank_i   (nonblank),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  // output register
  assign res_ready = !out_valid_q || out_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.op_kind = out_q.kind;
  assign out_o.op_line = out_q.line;
  assign out_o.op_char = out_q.ch;

endmodule

>>> rtl/core/tdsr_text_store.sv
// ----------------------------------------------------------------------------
// tdsr_text_store
// Text memory with per-row visible lengths and the edit cursor.
// ----------------------------------------------------------------------------
module tdsr_text_store import tdsr_pkg::*; #(
  parameter int TEXT_ROWS = 8,
  parameter int TEXT_COLS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  txt_cmd_t                             txt_cmd_i,
  input  logic [ROW_W-1:0]                     scan_row_i,
  output logic [COL_W-1:0]                     scan_len_o,
  output logic [ROW_SLOTS-1:0]                 nonblank_o,
  input  logic [ROW_W+col_idx_w(TEXT_COLS)-1:0] rd_addr_i,
  output logic [CHAR_W-1:0]                    rd_data_o
);

  localparam int CW    = col_idx_w(TEXT_COLS);
  localparam int DEPTH = ROW_SLOTS * (1 << CW);
  localparam logic [ITER_W-1:0] ROWS_C = ITER_W'(TEXT_ROWS);
  localparam logic [COL_W-1:0]  COLS_C = COL_W'(TEXT_COLS);

  logic [CHAR_W-1:0] text_mem_q [DEPTH];
  logic [CHAR_W-1:0] rd_data_q;

  logic [ROW_W-1:0] edit_row_q, edit_row_d;
  logic [COL_W-1:0] edit_col_q, edit_col_d;
  // visible text of the edit row still reaches the cursor
  logic             run_q, run_d;
  logic [COL_W-1:0] vis_q [ROW_SLOTS];
  logic [COL_W-1:0] vis_d [ROW_SLOTS];
  logic             wr_en;

  always_comb begin
    edit_row_d = edit_row_q;
    edit_col_d = edit_col_q;
    run_d      = run_q;
    vis_d      = vis_q;
    wr_en      = 1'b0;
    priority if (txt_cmd_i.sel) begin
      edit_row_d = txt_cmd_i.row;
      edit_col_d = '0;
      run_d      = 1'b1;
      if ({1'b0, txt_cmd_i.row} < ROWS_C) begin
        vis_d[txt_cmd_i.row] = '0;
      end
    end else if (txt_cmd_i.app && ({1'b0, edit_row_q} < ROWS_C) && (edit_col_q < COLS_C)) begin
      wr_en      = 1'b1;
      edit_col_d = edit_col_q + COL_W'(1);
      if (run_q && (txt_cmd_i.ch != CHAR_NUL)) begin
        vis_d[edit_row_q] = edit_col_q + COL_W'(1);
      end else begin
        run_d = 1'b0;
      end
    end else if (txt_cmd_i.clr) begin
      for (int r = 0; r < ROW_SLOTS; r++) begin
        vis_d[r] = '0;
      end
      // column 0 now reads as end of text, so only a write there can extend
      run_d = (edit_col_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edit_row_q <= '0;
      edit_col_q <= '0;
      run_q      <= 1'b1;
      for (int r = 0; r < ROW_SLOTS; r++) begin
        vis_q[r] <= '0;
      end
    end else begin
      edit_row_q <= edit_row_d;
      edit_col_q <= edit_col_d;
      run_q      <= run_d;
      vis_q      <= vis_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      text_mem_q[{edit_row_q, edit_col_q[CW-1:0]}] <= txt_cmd_i.ch;
    end
    rd_data_q <= text_mem_q[rd_addr_i];
  end

  always_comb begin
    for (int r = 0; r < ROW_SLOTS; r++) begin
      nonblank_o[r] = (vis_q[r] != '0);
    end
  end

  assign scan_len_o = vis_q[scan_row_i];
  assign rd_data_o  = rd_data_q;

endmodule

>>> rtl/core/tdsr_row_step.sv
// ----------------------------------------------------------------------------
// tdsr_row_step
// Shared row stepper: next row with wrap, blank test and first-row match.
// ----------------------------------------------------------------------------
module tdsr_row_step import tdsr_pkg::*; #(
  parameter int TEXT_ROWS = 8
) (
  input  logic [ROW_W-1:0]     scan_i,
  input  logic [ROW_W-1:0]     first_i,
  input  logic [ROW_SLOTS-1:0] nonblank_i,
  output row_step_t            step_o
);

  localparam logic [ITER_W-1:0] ROWS_C = ITER_W'(TEXT_ROWS);

  logic [ITER_W-1:0] inc;
  logic [ROW_W-1:0]  nxt;

  always_comb begin
    inc = {1'b0, scan_i} + ITER_W'(1);
    nxt = (inc >= ROWS_C) ? '0 : inc[ROW_W-1:0];
    step_o.next       = nxt;
    step_o.next_nb    = nonblank_i[nxt];
    step_o.next_first = (nxt == first_i);
    step_o.cur_nb     = nonblank_i[scan_i];
  end

endmodule

>>> rtl/core/tdsr_refresh_seq.sv
// ----------------------------------------------------------------------------
// tdsr_refresh_seq
// Command sequencer: decodes items, walks rows one step a cycle through the
// shared row stepper, snapshots a line and builds each screen operation.
// ----------------------------------------------------------------------------
module tdsr_refresh_seq import tdsr_pkg::*; #(
  parameter int TEXT_ROWS = 8,
  parameter int TEXT_COLS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  item_valid_i,
  output logic                                  item_ready_o,
  input  item_t                                 item_i,
  input  cfg_t                                  cfg_i,
  output txt_cmd_t                              txt_cmd_o,
  output logic [ROW_W-1:0]                      scan_row_o,
  input  logic [COL_W-1:0]                      scan_len_i,
  input  logic [ROW_SLOTS-1:0]                  nonblank_i,
  output logic [ROW_W+col_idx_w(TEXT_COLS)-1:0] rd_addr_o,
  input  logic [CHAR_W-1:0]                     rd_data_i,
  output logic                                  res_valid_o,
  input  logic                                  res_ready_i,
  output result_t                               res_o
);

  localparam int CW = col_idx_w(TEXT_COLS);
  localparam logic [ITER_W-1:0] ROWS_C = ITER_W'(TEXT_ROWS);
  localparam logic [COL_W-1:0]  COLS_C = COL_W'(TEXT_COLS);

  seq_state_e        state_q, state_d;
  item_t             item_q, item_d;
  result_t           res_q, res_d;
  logic [ROW_W-1:0]  first_q, first_d;
  logic [ROW_W-1:0]  scan_q, scan_d;
  logic [ROW_W-1:0]  slot_q, slot_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic              active_q, active_d;
  logic              exh_q, exh_d;
  logic [COL_W-1:0]  len_q, len_d;
  logic [TIME_W-1:0] last_q, last_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic [COL_W-1:0]  copy_idx_q, copy_idx_d;
  logic              cp_wr_en_q, cp_wr_en_d;
  logic [CW-1:0]     cp_wr_idx_q, cp_wr_idx_d;
  logic [CHAR_W-1:0] line_copy_q [TEXT_COLS];

  row_step_t         step;
  logic [TIME_W-1:0] elapsed;
  logic              gate_block;
  logic [LINES_W-1:0] lines_eff;
  logic [LINES_W-1:0] filled;
  logic              few_rows;
  logic [ROW_W-1:0]  slot_nx;
  logic [CHAR_W-1:0] wr_char;
  logic              done;

  tdsr_row_step #(
    .TEXT_ROWS (TEXT_ROWS)
  ) u_row_step (
    .scan_i     (scan_q),
    .first_i    (first_q),
    .nonblank_i (nonblank_i),
    .step_o     (step)
  );

  assign elapsed    = item_q.now_ms - last_q;
  assign gate_block = elapsed < TIME_W'(cfg_i.interval);
  assign lines_eff  = (cfg_i.lines > MAX_LINES) ? MAX_LINES : cfg_i.lines;
  assign filled     = LINES_W'($countones(nonblank_i));
  assign few_rows   = filled <= lines_eff;
  assign slot_nx    = slot_q + ROW_W'(1);
  assign wr_char    = (col_q < len_q) ? line_copy_q[col_q[CW-1:0]] : CHAR_SPACE;

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    res_d       = res_q;
    first_d     = first_q;
    scan_d      = scan_q;
    slot_d      = slot_q;
    col_d       = col_q;
    active_d    = active_q;
    exh_d       = exh_q;
    len_d       = len_q;
    last_d      = last_q;
    iter_d      = iter_q;
    copy_idx_d  = copy_idx_q;
    cp_wr_en_d  = 1'b0;
    cp_wr_idx_d = cp_wr_idx_q;
    txt_cmd_o   = '0;
    txt_cmd_o.row = item_q.row_index;
    txt_cmd_o.ch  = item_q.char_code;
    item_ready_o = 1'b0;
    res_valid_o  = 1'b0;
    done         = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          item_d  = item_i;
          state_d = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        state_d = ST_IDLE;
        case (item_q.cmd)
          CMD_SELECT: txt_cmd_o.sel = 1'b1;
          CMD_APPEND: txt_cmd_o.app = 1'b1;
          CMD_CLEAR: begin
            txt_cmd_o.clr = 1'b1;
            res_d   = '{kind: OP_CLEAR, line: '0, ch: CHAR_NUL};
            state_d = ST_EMIT;
          end
          CMD_STEP: begin
            if (!gate_block) begin
              if (!active_q) begin
                iter_d  = '0;
                state_d = ST_SEEK;
              end else begin
                res_d = '{kind: OP_WRITE, line: '0, ch: wr_char};
                col_d = col_q + COL_W'(1);
                if (col_q + COL_W'(1) >= COLS_C) begin
                  active_d = 1'b0;
                  iter_d   = '0;
                  state_d  = ST_NEXT_ROW;
                end else begin
                  state_d = ST_EMIT;
                end
              end
            end
          end
          CMD_RESTART: begin
            first_d  = '0;
            scan_d   = '0;
            slot_d   = '0;
            active_d = 1'b0;
            exh_d    = 1'b0;
            iter_d   = '0;
            state_d  = ST_SEEK;
          end
          default: state_d = ST_IDLE;
        endcase
      end

      // skip blank rows until a filled one or all rows seen
      ST_SEEK: begin
        if ((iter_q == ROWS_C) || exh_q || step.cur_nb) begin
          len_d      = exh_q ? '0 : scan_len_i;
          copy_idx_d = '0;
          state_d    = ST_COPY;
        end else begin
          scan_d = step.next;
          iter_d = iter_q + ITER_W'(1);
          if (step.next_first) begin
            exh_d = 1'b1;
          end
        end
      end

      // one byte a cycle out of the text memory into the line snapshot
      ST_COPY: begin
        if (copy_idx_q == len_q) begin
          res_d    = '{kind: OP_SETPOS, line: slot_q, ch: CHAR_NUL};
          col_d    = '0;
          active_d = 1'b1;
          state_d  = ST_EMIT;
        end else begin
          cp_wr_en_d  = 1'b1;
          cp_wr_idx_d = copy_idx_q[CW-1:0];
          copy_idx_d  = copy_idx_q + COL_W'(1);
        end
      end

      ST_NEXT_ROW: begin
        if (iter_q == ROWS_C) begin
          done = 1'b1;
        end else begin
          scan_d = step.next;
          iter_d = iter_q + ITER_W'(1);
          if (step.next_first) begin
            exh_d = 1'b1;
            done  = 1'b1;
          end else if (step.next_nb) begin
            done = 1'b1;
          end
        end
        if (done) begin
          slot_d = slot_nx;
          if ((slot_nx == '0) || ({1'b0, slot_nx} >= lines_eff)) begin
            state_d = ST_FINISH;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end

      // end of screen: choose where the next screen starts
      ST_FINISH: begin
        exh_d   = 1'b0;
        slot_d  = '0;
        last_d  = item_q.now_ms;
        state_d = ST_EMIT;
        case (cfg_i.mode)
          MODE_CONT: begin
            if (few_rows) begin
              scan_d  = '0;
              first_d = '0;
            end else begin
              first_d = scan_q;
            end
          end
          MODE_PAGE: begin
            if (exh_q) begin
              scan_d  = '0;
              first_d = '0;
            end
          end
          default: begin
            if (few_rows) begin
              scan_d  = '0;
              first_d = '0;
            end else begin
              scan_d  = first_q;
              iter_d  = '0;
              state_d = ST_ROTATE;
            end
          end
        endcase
      end

      // by-row scroll: top of screen moves to the next filled row
      ST_ROTATE: begin
        if (iter_q == ROWS_C) begin
          first_d = scan_q;
          state_d = ST_EMIT;
        end else begin
          scan_d = step.next;
          iter_d = iter_q + ITER_W'(1);
          if (step.next_nb) begin
            first_d = step.next;
            state_d = ST_EMIT;
          end
        end
      end

      ST_EMIT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      first_q    <= '0;
      scan_q     <= '0;
      slot_q     <= '0;
      col_q      <= '0;
      active_q   <= 1'b0;
      exh_q      <= 1'b0;
      len_q      <= '0;
      last_q     <= '0;
      iter_q     <= '0;
      copy_idx_q <= '0;
      cp_wr_en_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      first_q    <= first_d;
      scan_q     <= scan_d;
      slot_q     <= slot_d;
      col_q      <= col_d;
      active_q   <= active_d;
      exh_q      <= exh_d;
      len_q      <= len_d;
      last_q     <= last_d;
      iter_q     <= iter_d;
      copy_idx_q <= copy_idx_d;
      cp_wr_en_q <= cp_wr_en_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    res_q       <= res_d;
    cp_wr_idx_q <= cp_wr_idx_d;
    // read data lands in the cycle after the address went out
    if (cp_wr_en_q) begin
      line_copy_q[cp_wr_idx_q] <= rd_data_i;
    end
  end

  assign scan_row_o = scan_q;
  assign rd_addr_o  = {scan_q, copy_idx_q[CW-1:0]};
  assign res_o      = res_q;

endmodule

>>> rtl/core/tdsr_checker.sv
// ----------------------------------------------------------------------------
// tdsr_checker
// Port-level checks of the refresher, bound to the top level.
// ----------------------------------------------------------------------------
module tdsr_checker import tdsr_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [KIND_W-1:0] op_kind_i,
  input logic [ROW_W-1:0]  op_line_i,
  input logic [CHAR_W-1:0] op_char_i
);

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(op_kind_i) &&
      $stable(op_line_i) && $stable(op_char_i))
    else $error("stalled output item changed");

  // every accepted item keeps the sequencer busy in the cycle after it is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted back to back");

  a_clear_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (op_kind_i == OP_CLEAR) |-> (op_line_i == '0) && (op_char_i == '0))
    else $error("clear operation with non-zero payload");

  a_write_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (op_kind_i == OP_WRITE) |-> (op_line_i == '0))
    else $error("write operation carries a line");

endmodule

bind text_display_scroll_refresher_core tdsr_checker u_tdsr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .op_kind_i   (out_o.op_kind),
  .op_line_i   (out_o.op_line),
  .op_char_i   (out_o.op_char)
);
